// File: rtl/melody_note_sequencer_top_macros.svh
// Assertion macros for the melody note sequencer checker.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef MELODY_NOTE_SEQUENCER_TOP_MACROS_SVH
`define MELODY_NOTE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define MNS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MNS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/mns_pkg.sv
// Package for the melody note sequencer: request codes, command and result types,
// sequencer states and arithmetic constants. Depends on nothing.
package mns_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_ADD   = 3'd1;
	localparam logic [2:0] REQ_PLAY  = 3'd2;
	localparam logic [2:0] REQ_STOP  = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	// x / 10 as (x * RECIP) >> RECIP_SHIFT, exact for x below 2**22
	localparam logic [19:0] RECIP_TEN   = 20'd838861;
	localparam int          RECIP_SHIFT = 23;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_ADD,
		CMD_PLAY,
		CMD_STOP,
		CMD_CLEAR,
		CMD_NOP
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] note_value;
		logic [15:0] note_ms;
	} cmd_entry_t;

	typedef struct packed {
		logic        tone_enable;
		logic [14:0] tone_freq;
		logic        is_playing;
		logic [5:0]  note_position;
		logic [5:0]  stored_notes;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCALE,
		ST_EMIT
	} seq_state_t;

endpackage

// File: rtl/mns_front.sv
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on mns_pkg.
module mns_front import mns_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [2:0]        req_type,
	input  logic signed [15:0] note_value,
	input  logic [15:0]       note_ms,
	output logic              cmd_valid,
	output cmd_entry_t        cmd,
	input  logic              cmd_pop
);

	localparam int FW = $clog2(CMDQ_DEPTH + 1);

	cmd_entry_t       slot_q [CMDQ_DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [FW-1:0]    fill_q;
	cmd_t             kind;
	logic             wr;
	logic             rd;

	always_comb begin
		case (req_type)
			REQ_TICK:  kind = CMD_TICK;
			REQ_ADD:   kind = CMD_ADD;
			REQ_PLAY:  kind = CMD_PLAY;
			REQ_STOP:  kind = CMD_STOP;
			REQ_CLEAR: kind = CMD_CLEAR;
			default:   kind = CMD_NOP;
		endcase
	end

	assign full      = (fill_q == FW'(CMDQ_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign wr        = push && !full;
	assign rd        = cmd_pop && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= '{cmd: kind, note_value: note_value, note_ms: note_ms};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (wr) wr_ptr_q <= ~wr_ptr_q;
			if (rd) rd_ptr_q <= ~rd_ptr_q;
			if (wr && !rd) fill_q <= fill_q + FW'(1);
			else if (rd && !wr) fill_q <= fill_q - FW'(1);
		end
	end

endmodule

// File: rtl/mns_back.sv
// Back end: player sequencer with the note table memory and gate arithmetic.
// Depends on mns_pkg.
module mns_back import mns_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_entry_t cmd,
	output logic       cmd_pop,
	output logic       res_push,
	output result_t    res,
	input  logic       res_full
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [31:0]   mem [TABLE_DEPTH];
	logic [31:0]   rd_data_q;

	seq_state_t    state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic          playing_q;
	logic          sounding_q;
	logic [15:0]   elapsed_q;
	logic [15:0]   note_end_q;
	logic [15:0]   gate_off_q;
	logic [14:0]   freq_q;
	logic [19:0]   dur9_q;
	logic          gate_chk_q;

	logic          take;
	logic          tick_live;
	logic [16:0]   elapsed_inc;
	logic          step;
	logic [CW:0]   pos_inc;
	logic          last;
	logic          rd_en;
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic [15:0]   dur;
	logic [39:0]   prod;
	logic [15:0]   gate;
	logic [CW+5:0] pos_ext;
	logic [CW+5:0] count_ext;

	assign take        = (state_q == ST_IDLE) && cmd_valid;
	assign tick_live   = playing_q && (count_q != '0);
	assign elapsed_inc = {1'b0, elapsed_q} + 17'd1;
	assign step        = (elapsed_inc >= {1'b0, note_end_q});
	assign pos_inc     = {1'b0, pos_q} + (CW+1)'(1);
	assign last        = (pos_inc >= {1'b0, count_q});
	assign rd_addr     = (cmd.cmd == CMD_PLAY) ? '0 : pos_inc[AW-1:0];
	assign dur         = (rd_data_q[15:0] == 16'd0) ? 16'd1 : rd_data_q[15:0];
	assign prod        = {20'd0, dur9_q} * {20'd0, RECIP_TEN};
	assign gate        = prod[RECIP_SHIFT+15:RECIP_SHIFT];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = rd_en ? ST_LOAD : ST_EMIT;
				end
			end
			ST_LOAD:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!res_full) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = take;
		wr_en    = take && (cmd.cmd == CMD_ADD) && (count_q < CW'(TABLE_DEPTH));
		rd_en    = take && (((cmd.cmd == CMD_PLAY) && (count_q != '0)) ||
			((cmd.cmd == CMD_TICK) && tick_live && step && !last));
		res_push = (state_q == ST_EMIT) && !res_full;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[count_q[AW-1:0]] <= {cmd.note_value, cmd.note_ms};
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			playing_q  <= 1'b0;
			sounding_q <= 1'b0;
			elapsed_q  <= '0;
			note_end_q <= '0;
			gate_off_q <= '0;
			gate_chk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.cmd)
							CMD_TICK: begin
								if (tick_live) begin
									if (step) begin
										elapsed_q <= 16'(elapsed_inc - {1'b0, note_end_q});
										pos_q     <= pos_inc[CW-1:0];
										if (last) begin
											playing_q  <= 1'b0;
											sounding_q <= 1'b0;
										end
										gate_chk_q <= 1'b1;
									end else begin
										elapsed_q <= elapsed_inc[15:0];
										if (sounding_q && elapsed_inc >= {1'b0, gate_off_q})
											sounding_q <= 1'b0;
									end
								end
							end
							CMD_ADD: begin
								if (wr_en) count_q <= count_q + CW'(1);
							end
							CMD_PLAY: begin
								if (count_q == '0) begin
									playing_q  <= 1'b0;
									sounding_q <= 1'b0;
								end else begin
									playing_q  <= 1'b1;
									pos_q      <= '0;
									elapsed_q  <= '0;
									gate_chk_q <= 1'b0;
								end
							end
							CMD_STOP: begin
								playing_q  <= 1'b0;
								sounding_q <= 1'b0;
							end
							CMD_CLEAR: begin
								count_q    <= '0;
								pos_q      <= '0;
								playing_q  <= 1'b0;
								sounding_q <= 1'b0;
								elapsed_q  <= '0;
								note_end_q <= '0;
								gate_off_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOAD: begin
					note_end_q <= dur;
					sounding_q <= (rd_data_q[31:16] != 16'd0) && !rd_data_q[31];
				end
				ST_SCALE: begin
					gate_off_q <= gate;
					if (gate_chk_q && sounding_q && elapsed_q >= gate) sounding_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			freq_q <= rd_data_q[30:16];
			dur9_q <= {1'b0, dur, 3'b000} + {4'd0, dur};
		end
	end

	assign pos_ext   = {6'd0, pos_q};
	assign count_ext = {6'd0, count_q};

	always_comb begin
		res.tone_enable   = sounding_q;
		res.tone_freq     = sounding_q ? freq_q : 15'd0;
		res.is_playing    = playing_q;
		res.note_position = pos_ext[5:0];
		res.stored_notes  = count_ext[5:0];
	end

endmodule

// File: rtl/mns_out_queue.sv
// Result queue between the sequencer and the result ports.
// Depends on mns_pkg.
module mns_out_queue import mns_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_push,
	input  result_t res,
	output logic    res_full,
	output logic    empty,
	input  logic    pop,
	output result_t head
);

	localparam int FW = $clog2(RESQ_DEPTH + 1);

	result_t       slot_q [RESQ_DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic          rd;

	assign res_full = (fill_q == FW'(RESQ_DEPTH));
	assign empty    = (fill_q == '0);
	assign rd       = pop && !empty;
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_push) slot_q[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (res_push) wr_ptr_q <= ~wr_ptr_q;
			if (rd) rd_ptr_q <= ~rd_ptr_q;
			if (res_push && !rd) fill_q <= fill_q + FW'(1);
			else if (rd && !res_push) fill_q <= fill_q - FW'(1);
		end
	end

endmodule

// File: rtl/melody_note_sequencer_top.sv
// Top level of the melody note sequencer: front end, player back end, result queue.
// Depends on mns_pkg, mns_front, mns_back and mns_out_queue.
//
//  channel   handshake           payload
//  request   push / full         req_type, note_value, note_ms
//  result    empty / pop         tone_enable, tone_freq, is_playing,
//                                note_position, stored_notes
//
// The sequencer takes a request from idle to emit; a note start (play, or a tick
// that steps on) passes load, for the registered note table read, and scale, for
// the nine-tenths gate multiply. Two requests and two results may be queued.
// Reset clears all control state at once; the note table has no reset and needs
// no clearing pass. Either side may stall without losing a transfer.
module melody_note_sequencer_top import mns_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         req_type,
	input  logic signed [15:0] note_value,
	input  logic [15:0]        note_ms,
	output logic               empty,
	input  logic               pop,
	output logic               tone_enable,
	output logic [14:0]        tone_freq,
	output logic               is_playing,
	output logic [5:0]         note_position,
	output logic [5:0]         stored_notes
);

	logic       cmd_valid;
	cmd_entry_t cmd;
	logic       cmd_pop;
	logic       res_push;
	result_t    res;
	logic       res_full;
	result_t    head;

	mns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.note_value (note_value),
		.note_ms    (note_ms),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	mns_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	mns_out_queue u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign tone_enable   = head.tone_enable;
	assign tone_freq     = head.tone_freq;
	assign is_playing    = head.is_playing;
	assign note_position = head.note_position;
	assign stored_notes  = head.stored_notes;

endmodule

// File: rtl/mns_checker.sv
// Port-level checker for the melody note sequencer, bound to the top level.
// Depends on melody_note_sequencer_top_macros.svh.
`include "melody_note_sequencer_top_macros.svh"

module mns_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        tone_enable,
	input logic [14:0] tone_freq,
	input logic        is_playing,
	input logic [5:0]  stored_notes
);

	logic [2:0] pending_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = push && !full;
	assign out_xfer = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`MNS_ASSERT_IMP(a_silent_freq, !empty && !tone_enable, tone_freq == 15'd0)
	`MNS_ASSERT_IMP(a_sound_playing, !empty && tone_enable, is_playing)
	`MNS_ASSERT_IMP(a_no_spurious, !empty, pending_q != 3'd0)
	`MNS_ASSERT_NXT(a_stall_hold, !empty && !pop, !empty && $stable(tone_freq) && $stable(stored_notes))

endmodule

bind melody_note_sequencer_top mns_checker u_chk (.*);
